// ----- rtl/pwbt_pkg.sv -----
`default_nettype none

package pwbt_pkg;

    // frame length in bits, default
    localparam int unsigned BITS_PER_CODE_DEF = 8;

    // configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned TICK_W     = 16;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CARRIER_ENABLE     = 3'd0,
        REG_CARRIER_HALF_TICKS = 3'd1,
        REG_SHORT_MARK_TICKS   = 3'd2,
        REG_LONG_MARK_TICKS    = 3'd3,
        REG_SPACE_TICKS        = 3'd4
    } t_reg_idx;

    localparam logic              CARRIER_ENABLE_RST     = 1'b1;
    localparam logic [TICK_W-1:0] CARRIER_HALF_TICKS_RST = 16'd13;
    localparam logic [TICK_W-1:0] SHORT_MARK_TICKS_RST   = 16'd100;
    localparam logic [TICK_W-1:0] LONG_MARK_TICKS_RST    = 16'd500;
    localparam logic [TICK_W-1:0] SPACE_TICKS_RST        = 16'd500;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] code_byte;
    } t_in_word;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_rejected;
        logic frame_done;
    } t_out_word;

    typedef struct packed {
        logic              carrier_enable;
        logic [TICK_W-1:0] carrier_half_ticks;
        logic [TICK_W-1:0] short_mark_ticks;
        logic [TICK_W-1:0] long_mark_ticks;
        logic [TICK_W-1:0] space_ticks;
    } t_cfg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_MARK  = 3'b010,
        PH_SPACE = 3'b100
    } t_phase;

    // a zero length behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pwbt_regs.sv -----
`default_nettype none

module pwbt_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pwbt_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [pwbt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [pwbt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output pwbt_pkg::t_cfg                         o_cfg
);
    import pwbt_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_enable     <= CARRIER_ENABLE_RST;
            r_cfg.carrier_half_ticks <= CARRIER_HALF_TICKS_RST;
            r_cfg.short_mark_ticks   <= SHORT_MARK_TICKS_RST;
            r_cfg.long_mark_ticks    <= LONG_MARK_TICKS_RST;
            r_cfg.space_ticks        <= SPACE_TICKS_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_CARRIER_ENABLE:     r_cfg.carrier_enable     <= pwdata[0];
                REG_CARRIER_HALF_TICKS: r_cfg.carrier_half_ticks <= pwdata[TICK_W-1:0];
                REG_SHORT_MARK_TICKS:   r_cfg.short_mark_ticks   <= pwdata[TICK_W-1:0];
                REG_LONG_MARK_TICKS:    r_cfg.long_mark_ticks    <= pwdata[TICK_W-1:0];
                REG_SPACE_TICKS:        r_cfg.space_ticks        <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_CARRIER_ENABLE:     prdata = APB_DATA_W'(r_cfg.carrier_enable);
            REG_CARRIER_HALF_TICKS: prdata = APB_DATA_W'(r_cfg.carrier_half_ticks);
            REG_SHORT_MARK_TICKS:   prdata = APB_DATA_W'(r_cfg.short_mark_ticks);
            REG_LONG_MARK_TICKS:    prdata = APB_DATA_W'(r_cfg.long_mark_ticks);
            REG_SPACE_TICKS:        prdata = APB_DATA_W'(r_cfg.space_ticks);
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/pwbt_engine.sv -----
`default_nettype none

module pwbt_engine #(
    parameter int unsigned BITS_PER_CODE = pwbt_pkg::BITS_PER_CODE_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire pwbt_pkg::t_in_word i_word,
    input  wire pwbt_pkg::t_cfg     i_cfg,
    output pwbt_pkg::t_out_word o_result
);
    import pwbt_pkg::*;

    localparam int unsigned POS_W = $clog2(BITS_PER_CODE + 1);

    logic [7:0]        r_shift, n_shift;
    logic [POS_W-1:0]  r_pos,   n_pos;
    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_pc,    n_pc;
    logic [TICK_W-1:0] r_cc,    n_cc;
    logic              r_cl,    n_cl;

    logic [TICK_W-1:0] pc_dec, cc_dec;
    logic [POS_W-1:0]  pos_inc;
    logic              done, rejected;

    assign pc_dec  = (r_pc != '0) ? r_pc - TICK_W'(1) : '0;
    assign cc_dec  = (r_cc != '0) ? r_cc - TICK_W'(1) : '0;
    assign pos_inc = r_pos + POS_W'(1);

    always_comb begin
        n_shift  = r_shift;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_pc     = r_pc;
        n_cc     = r_cc;
        n_cl     = r_cl;
        done     = 1'b0;
        rejected = 1'b0;
        if (i_word.command == CMD_LOAD) begin
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                n_shift = i_word.code_byte;
                n_pos   = '0;
                n_phase = PH_MARK;
                n_pc    = at_least_one(i_word.code_byte[0] ? i_cfg.long_mark_ticks
                                                           : i_cfg.short_mark_ticks);
            end
        end else begin
            // free-running carrier
            if (cc_dec == '0) begin
                n_cl = ~r_cl;
                n_cc = at_least_one(i_cfg.carrier_half_ticks);
            end else begin
                n_cc = cc_dec;
            end
            if (r_phase != PH_IDLE) begin
                if (pc_dec != '0) begin
                    n_pc = pc_dec;
                end else if (r_phase == PH_MARK) begin
                    n_phase = PH_SPACE;
                    n_pc    = at_least_one(i_cfg.space_ticks);
                end else begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_pos   = pos_inc;
                    if (pos_inc >= POS_W'(BITS_PER_CODE)) begin
                        n_phase = PH_IDLE;
                        n_pc    = '0;
                        done    = 1'b1;
                    end else begin
                        n_phase = PH_MARK;
                        n_pc    = at_least_one(r_shift[1] ? i_cfg.long_mark_ticks
                                                          : i_cfg.short_mark_ticks);
                    end
                end
            end
        end
    end

    always_comb begin
        o_result.line_level    = (n_phase == PH_MARK) && (i_cfg.carrier_enable ? n_cl : 1'b1);
        o_result.busy_res      = (n_phase != PH_IDLE);
        o_result.load_rejected = rejected;
        o_result.frame_done    = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_pos   <= '0;
            r_phase <= PH_IDLE;
            r_pc    <= '0;
            r_cc    <= '0;
            r_cl    <= 1'b0;
        end else if (i_step) begin
            r_shift <= n_shift;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_cl    <= n_cl;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ir_pulse_width_byte_transmitter_top.sv -----
// channel  | direction | valid        | stall        | payload
// ---------+-----------+--------------+--------------+----------------------
// in       | into      | i_in_valid   | o_in_stall   | i_in_word  (t_in_word)
// out      | out of    | o_out_valid  | i_out_stall  | o_out_word (t_out_word)
// config   | into      | psel/penable | pready       | paddr/pwdata/prdata
//
// one word per cycle sustained while the output is not stalled; from input to result
// a word passes the input register, then state update and the result register
// synchronous active-low reset returns the frame state machine to idle and
// the registers to their documented defaults
// a held result stalls the input register only, which stalls the input
// when it is also full

`default_nettype none

module ir_pulse_width_byte_transmitter_top #(
    parameter int unsigned BITS_PER_CODE = pwbt_pkg::BITS_PER_CODE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire pwbt_pkg::t_in_word              i_in_word,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pwbt_pkg::t_out_word                  o_out_word,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pwbt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pwbt_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pwbt_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import pwbt_pkg::*;

    t_cfg      cfg;
    t_out_word step_result;

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;
    // result register
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      advance;
    logic      in_take;

    // the held word moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    pwbt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame and carrier state, updated once per word leaving the input register
    pwbt_engine #(
        .BITS_PER_CODE (BITS_PER_CODE)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= step_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pwbt_checker.sv -----
`default_nettype none

module pwbt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire pwbt_pkg::t_out_word o_out_word,
    input wire logic                pready
);
    import pwbt_pkg::*;

    // a result stalled at the port stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // the frame end leaves the transmitter idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.frame_done |-> !o_out_word.busy_res
            && !o_out_word.line_level && !o_out_word.load_rejected)
        else $error("frame end reported while still busy");

    // a load is refused only while a frame is running
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.load_rejected |-> o_out_word.busy_res)
        else $error("load refused while idle");

    // the line is driven only inside a frame
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.line_level |-> o_out_word.busy_res)
        else $error("line high outside a frame");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind ir_pulse_width_byte_transmitter_top pwbt_checker u_pwbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .pready      (pready)
);

`default_nettype wire
